// ===== rtl/i2sst_pkg.sv =====
// ----------------------------------------------------------------------------
// I2S slot statistics package
// Shared widths, constants, register indexes and transaction payload types.
// ----------------------------------------------------------------------------
package i2sst_pkg;

    localparam int WORD_W   = 32;
    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 13;
    localparam int REG_IDX_W = 2;
    localparam int REG_DATA_W = 1;

    localparam int MAX_FRAMES_DEFAULT = 256;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_POS_MAX = 24'sh7F_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG_MIN = 24'sh80_0000;
    localparam int LJ_SHIFT = 8;

    localparam logic [REG_IDX_W-1:0] REG_STEREO_RAW_MODE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_USE_RIGHT_SLOT   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CONVERSION_LOW24 = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] slot_word;
        logic              is_right_slot;
        logic              end_of_read;
    } word_item_t;

    typedef struct packed {
        logic                       sample_valid;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_done;
        logic signed [SAMPLE_W-1:0] low_sample;
        logic signed [SAMPLE_W-1:0] high_sample;
        logic [SAMPLE_W-1:0]        peak_level;
        logic [COUNT_W-1:0]         zero_total;
        logic [COUNT_W-1:0]         nonzero_total;
        logic [COUNT_W-1:0]         repeat_total;
        logic [WORD_W-1:0]          raw_min;
        logic [WORD_W-1:0]          raw_max;
        logic [COUNT_W-1:0]         sample_total;
    } result_item_t;

endpackage

// ===== rtl/i2sst_stream_if.sv =====
// ----------------------------------------------------------------------------
// I2S slot statistics stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface i2sst_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/i2s_slot_sample_statistics_unit.sv =====
// ----------------------------------------------------------------------------
// I2S slot sample statistics unit
// Selects slot words, converts them to signed 24-bit samples and reports
// per-block min/max/peak, zero/nonzero/repeat counts and raw word extremes.
//
// Channel        Dir  Payload        Transaction
// word_stream    in   word_item_t    one raw slot word
// result_stream  out  result_item_t  sample and/or block summary
// wr_*           in   reg index/data register write, no handshake
//
// One word per cycle unless stalled; input register, then accumulator update
// and result register. Words not taken (unselected or block full) and not
// closing a block give no transaction. Reset loads the register defaults and
// clears all block accumulators. A stalled result holds the pipeline; a new
// word is still taken while the result register is being drained.
// ----------------------------------------------------------------------------
module i2s_slot_sample_statistics_unit
    import i2sst_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [REG_IDX_W-1:0]  wr_index,
    input  logic [REG_DATA_W-1:0] wr_data,
    i2sst_stream_if.sink          word_stream,
    i2sst_stream_if.source        result_stream
);

    localparam logic [COUNT_W-1:0] FRAME_LIMIT = COUNT_W'(MAX_FRAMES);

    logic stereo_reg;
    logic right_sel_reg;
    logic low24_reg;

    logic       s1_valid_reg;
    word_item_t s1_item_reg;

    logic         out_valid_reg;
    result_item_t out_item_reg;
    result_item_t out_item_next;

    logic signed [SAMPLE_W-1:0] run_min_reg,  run_min_next;
    logic signed [SAMPLE_W-1:0] run_max_reg,  run_max_next;
    logic [SAMPLE_W-1:0]        run_peak_reg, run_peak_next;
    logic [COUNT_W-1:0]         zeros_reg,    zeros_next;
    logic [COUNT_W-1:0]         nonzeros_reg, nonzeros_next;
    logic [COUNT_W-1:0]         repeats_reg,  repeats_next;
    logic [COUNT_W-1:0]         samples_reg,  samples_next;
    logic [WORD_W-1:0]          prev_word_reg, prev_word_next;
    logic                       prev_valid_reg, prev_valid_next;
    logic [WORD_W-1:0]          word_min_reg, word_min_next;
    logic [WORD_W-1:0]          word_max_reg, word_max_next;

    logic                       out_free;
    logic                       advance;
    logic                       selected;
    logic                       take;
    logic                       emit;
    logic                       last;
    logic [WORD_W-1:0]          raw;
    logic signed [SAMPLE_W-1:0] smp;
    logic [SAMPLE_W-1:0]        mag;

    assign out_free          = !out_valid_reg || result_stream.ready;
    assign advance           = s1_valid_reg && out_free;
    assign word_stream.ready = !s1_valid_reg || out_free;

    assign result_stream.valid = out_valid_reg;
    assign result_stream.data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_reg    <= 1'b1;
            right_sel_reg <= 1'b0;
            low24_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_STEREO_RAW_MODE:  stereo_reg    <= wr_data[0];
                REG_USE_RIGHT_SLOT:   right_sel_reg <= wr_data[0];
                REG_CONVERSION_LOW24: low24_reg     <= wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (word_stream.valid && word_stream.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_stream.valid && word_stream.ready)
        begin
            s1_item_reg <= word_stream.data;
        end
    end

    assign raw      = s1_item_reg.slot_word;
    assign last     = s1_item_reg.end_of_read;
    assign selected = !stereo_reg || (s1_item_reg.is_right_slot == right_sel_reg);
    assign take     = selected && (samples_reg < FRAME_LIMIT);
    assign emit     = take || last;
    assign smp      = low24_reg ? raw[SAMPLE_W-1:0] : raw[LJ_SHIFT +: SAMPLE_W];
    assign mag      = smp[SAMPLE_W-1] ? (~smp + 1'b1) : smp;

    always_comb
    begin
        run_min_next    = run_min_reg;
        run_max_next    = run_max_reg;
        run_peak_next   = run_peak_reg;
        zeros_next      = zeros_reg;
        nonzeros_next   = nonzeros_reg;
        repeats_next    = repeats_reg;
        samples_next    = samples_reg;
        prev_word_next  = prev_word_reg;
        prev_valid_next = prev_valid_reg;
        word_min_next   = word_min_reg;
        word_max_next   = word_max_reg;
        if (take)
        begin
            if (smp < run_min_reg)
                run_min_next = smp;
            if (smp > run_max_reg)
                run_max_next = smp;
            if (mag > run_peak_reg)
                run_peak_next = mag;
            if (smp == '0)
                zeros_next = zeros_reg + 1'b1;
            if (raw != '0)
                nonzeros_next = nonzeros_reg + 1'b1;
            if (prev_valid_reg && (raw == prev_word_reg))
                repeats_next = repeats_reg + 1'b1;
            prev_word_next  = raw;
            prev_valid_next = 1'b1;
            if (raw < word_min_reg)
                word_min_next = raw;
            if (raw > word_max_reg)
                word_max_next = raw;
            samples_next = samples_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_item_next              = '0;
        out_item_next.sample_valid = take;
        out_item_next.block_done   = last;
        if (take)
            out_item_next.sample = smp;
        if (last && (samples_next != '0))
        begin
            out_item_next.low_sample    = run_min_next;
            out_item_next.high_sample   = run_max_next;
            out_item_next.peak_level    = run_peak_next;
            out_item_next.zero_total    = zeros_next;
            out_item_next.nonzero_total = nonzeros_next;
            out_item_next.repeat_total  = repeats_next;
            out_item_next.raw_min       = word_min_next;
            out_item_next.raw_max       = word_max_next;
            out_item_next.sample_total  = samples_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_min_reg    <= SAMPLE_POS_MAX;
            run_max_reg    <= SAMPLE_NEG_MIN;
            run_peak_reg   <= '0;
            zeros_reg      <= '0;
            nonzeros_reg   <= '0;
            repeats_reg    <= '0;
            samples_reg    <= '0;
            prev_word_reg  <= '0;
            prev_valid_reg <= 1'b0;
            word_min_reg   <= '1;
            word_max_reg   <= '0;
        end
        else if (advance)
        begin
            if (last)
            begin
                run_min_reg    <= SAMPLE_POS_MAX;
                run_max_reg    <= SAMPLE_NEG_MIN;
                run_peak_reg   <= '0;
                zeros_reg      <= '0;
                nonzeros_reg   <= '0;
                repeats_reg    <= '0;
                samples_reg    <= '0;
                prev_word_reg  <= '0;
                prev_valid_reg <= 1'b0;
                word_min_reg   <= '1;
                word_max_reg   <= '0;
            end
            else
            begin
                run_min_reg    <= run_min_next;
                run_max_reg    <= run_max_next;
                run_peak_reg   <= run_peak_next;
                zeros_reg      <= zeros_next;
                nonzeros_reg   <= nonzeros_next;
                repeats_reg    <= repeats_next;
                samples_reg    <= samples_next;
                prev_word_reg  <= prev_word_next;
                prev_valid_reg <= prev_valid_next;
                word_min_reg   <= word_min_next;
                word_max_reg   <= word_max_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (result_stream.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2S slot sample statistics unit testbench
// Drives slot words through the valid/ready word channel with random gaps and
// result back-pressure. A local block-statistics predictor tracks every
// accepted word, queues the expected sample/summary transactions and compares
// each result transaction field by field. Covers both slots, mono mode, both
// conversions, empty and full blocks, repeats and mid-block register changes.
// ----------------------------------------------------------------------------
module testbench;

    import i2sst_pkg::*;

    localparam int BLOCK_LIMIT  = MAX_FRAMES_DEFAULT;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_WORDS = 350;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  wr_index;
    logic [REG_DATA_W-1:0] wr_data;

    i2sst_stream_if #(.T(word_item_t))   word_if ();
    i2sst_stream_if #(.T(result_item_t)) result_if ();

    i2s_slot_sample_statistics_unit #(
        .MAX_FRAMES (BLOCK_LIMIT)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .word_stream   (word_if),
        .result_stream (result_if)
    );

    // register mirror
    bit cfg_stereo = 1'b1;
    bit cfg_right  = 1'b0;
    bit cfg_low24  = 1'b0;

    // block accumulators
    logic signed [SAMPLE_W-1:0] blk_min;
    logic signed [SAMPLE_W-1:0] blk_max;
    logic [SAMPLE_W-1:0]        blk_peak;
    logic [COUNT_W-1:0]         blk_zeros;
    logic [COUNT_W-1:0]         blk_nonzeros;
    logic [COUNT_W-1:0]         blk_repeats;
    logic [COUNT_W-1:0]         blk_samples;
    logic [WORD_W-1:0]          blk_prev_word;
    bit                         blk_prev_valid;
    logic [WORD_W-1:0]          blk_word_min;
    logic [WORD_W-1:0]          blk_word_max;

    result_item_t expected_results[$];
    int unsigned  mismatches  = 0;
    int unsigned  words_sent  = 0;
    int unsigned  cycle_count = 0;
    bit           gaps_enabled = 1'b1;
    logic [WORD_W-1:0] last_raw = '0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout, %0d results outstanding", $time, expected_results.size());
            $display("i2s_slot_sample_statistics_unit: mismatch");
            $finish;
        end
    end

    function automatic void clear_block_stats();
        blk_min        = SAMPLE_POS_MAX;
        blk_max        = SAMPLE_NEG_MIN;
        blk_peak       = '0;
        blk_zeros      = '0;
        blk_nonzeros   = '0;
        blk_repeats    = '0;
        blk_samples    = '0;
        blk_prev_word  = '0;
        blk_prev_valid = 1'b0;
        blk_word_min   = '1;
        blk_word_max   = '0;
    endfunction

    function automatic bit predict_slot_result(input word_item_t w, output result_item_t r);
        logic [SAMPLE_W-1:0]        conv;
        logic signed [SAMPLE_W-1:0] s;
        logic [SAMPLE_W-1:0]        mag;
        bit                         picked;
        bit                         taken;
        r      = '0;
        picked = !cfg_stereo || (w.is_right_slot == cfg_right);
        taken  = picked && (blk_samples < BLOCK_LIMIT);
        if (taken)
        begin
            conv = cfg_low24 ? w.slot_word[SAMPLE_W-1:0] : w.slot_word[WORD_W-1:LJ_SHIFT];
            s    = signed'(conv);
            mag  = s[SAMPLE_W-1] ? (~conv + 1'b1) : conv;
            if (s < blk_min)
                blk_min = s;
            if (s > blk_max)
                blk_max = s;
            if (mag > blk_peak)
                blk_peak = mag;
            if (s == 0)
                blk_zeros++;
            if (w.slot_word != 0)
                blk_nonzeros++;
            if (blk_prev_valid && w.slot_word == blk_prev_word)
                blk_repeats++;
            blk_prev_word  = w.slot_word;
            blk_prev_valid = 1'b1;
            if (w.slot_word < blk_word_min)
                blk_word_min = w.slot_word;
            if (w.slot_word > blk_word_max)
                blk_word_max = w.slot_word;
            blk_samples++;
            r.sample_valid = 1'b1;
            r.sample       = s;
        end
        if (!taken && !w.end_of_read)
            return 1'b0;
        if (w.end_of_read)
        begin
            r.block_done = 1'b1;
            if (blk_samples != 0)
            begin
                r.low_sample    = blk_min;
                r.high_sample   = blk_max;
                r.peak_level    = blk_peak;
                r.zero_total    = blk_zeros;
                r.nonzero_total = blk_nonzeros;
                r.repeat_total  = blk_repeats;
                r.raw_min       = blk_word_min;
                r.raw_max       = blk_word_max;
                r.sample_total  = blk_samples;
            end
            clear_block_stats();
        end
        return 1'b1;
    endfunction

    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (!gaps_enabled || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word(input logic [WORD_W-1:0] prev);
        case ($urandom_range(11))
            0: return '0;
            1, 2: return prev;
            3: return '1;
            4: return 32'h8000_0000 | ($urandom() & 32'h0080_00FF);
            5: return 32'h7FFF_FF00 | ($urandom() & 32'h0000_00FF);
            6: return $urandom() & 32'h0000_00FF;
            7: return $urandom() & 32'hFF80_0000;
            8: return $urandom() & 32'hFF00_0001;
            default: return $urandom();
        endcase
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_item_t want;
        result_item_t got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = result_if.data;
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected result transaction, expected none actual %h",
                         $time, got);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("sample_valid",  want.sample_valid,  got.sample_valid);
                check_field("sample",        want.sample,        got.sample);
                check_field("block_done",    want.block_done,    got.block_done);
                check_field("low_sample",    want.low_sample,    got.low_sample);
                check_field("high_sample",   want.high_sample,   got.high_sample);
                check_field("peak_level",    want.peak_level,    got.peak_level);
                check_field("zero_total",    want.zero_total,    got.zero_total);
                check_field("nonzero_total", want.nonzero_total, got.nonzero_total);
                check_field("repeat_total",  want.repeat_total,  got.repeat_total);
                check_field("raw_min",       want.raw_min,       got.raw_min);
                check_field("raw_max",       want.raw_max,       got.raw_max);
                check_field("sample_total",  want.sample_total,  got.sample_total);
            end
        end
    end

    initial
    begin : result_backpressure
        int unsigned hold;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_if.ready <= 1'b1;
            hold = $urandom_range(1, 12);
            repeat (hold) @(posedge clk);
            hold = random_gap();
            if (hold > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] raw, input bit right, input bit last);
        word_item_t   w;
        result_item_t r;
        int unsigned  gap;
        w.slot_word     = raw;
        w.is_right_slot = right;
        w.end_of_read   = last;
        gap = random_gap();
        if (gap > 0)
        begin
            word_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_if.valid <= 1'b1;
        word_if.data  <= w;
        do
            @(posedge clk);
        while (!word_if.ready);
        if (predict_slot_result(w, r))
            expected_results.push_back(r);
        last_raw = raw;
        words_sent++;
    endtask

    task automatic wait_drained();
        word_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_config(input bit stereo, input bit right, input bit low24);
        wait_drained();
        wr_en    <= 1'b1;
        wr_index <= REG_STEREO_RAW_MODE;
        wr_data  <= stereo;
        @(posedge clk);
        wr_index <= REG_USE_RIGHT_SLOT;
        wr_data  <= right;
        @(posedge clk);
        wr_index <= REG_CONVERSION_LOW24;
        wr_data  <= low24;
        @(posedge clk);
        wr_en    <= 1'b0;
        cfg_stereo = stereo;
        cfg_right  = right;
        cfg_low24  = low24;
    endtask

    task automatic send_block(input int frames, input bit noisy);
        bit slot;
        bit last;
        for (int f = 0; f < frames; f++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                slot = k[0];
                last = (f == frames - 1) && (k == 1);
                if (noisy)
                begin
                    slot = 1'($urandom_range(1));
                    last = last || ($urandom_range(15) == 0);
                end
                send_word(pick_word(last_raw), slot, last);
            end
        end
    endtask

    task automatic test_slot_selection();
        // empty block: only an unselected word closes it
        send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'h1234_5678, 1'b1, 1'b0);
        send_word(32'h7FFF_FF00, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b1, 1'b0);
        send_word(32'h8000_0000, 1'b0, 1'b0);
        send_word(32'hA5A5_A5A5, 1'b1, 1'b0);
        send_word(32'h8000_0000, 1'b0, 1'b0);
        send_word(32'h5A5A_5A5A, 1'b1, 1'b0);
        send_word(32'h0000_00FF, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
    endtask

    task automatic test_conversion_modes();
        apply_config(1'b0, 1'b0, 1'b1);
        send_word(32'h0080_0000, 1'b0, 1'b0);
        send_word(32'hAB7F_FFFF, 1'b1, 1'b0);
        send_word(32'hFF00_0000, 1'b0, 1'b0);
        send_word(32'hFF00_0000, 1'b1, 1'b1);
        apply_config(1'b1, 1'b1, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h0000_0001, 1'b1, 1'b0);
        send_word(32'h0000_0002, 1'b0, 1'b0);
        // register change inside an open block
        apply_config(1'b1, 1'b1, 1'b0);
        send_word(32'h0000_0003, 1'b0, 1'b0);
        send_word(32'h8000_0000, 1'b1, 1'b1);
        apply_config(1'b0, 1'b1, 1'b0);
        send_word(32'hFFFF_FF00, 1'b0, 1'b0);
        apply_config(1'b1, 1'b0, 1'b1);
        send_word(32'h00FF_FFFF, 1'b1, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b1);
    endtask

    task automatic test_block_full();
        apply_config(1'b0, 1'b0, 1'b0);
        for (int i = 0; i < BLOCK_LIMIT + 6; i++)
            send_word(pick_word(last_raw), 1'($urandom_range(1)), i == BLOCK_LIMIT + 5);
        for (int i = 0; i < BLOCK_LIMIT; i++)
            send_word(pick_word(last_raw), 1'($urandom_range(1)), i == BLOCK_LIMIT - 1);
    endtask

    task automatic test_random_blocks();
        int unsigned stop_at;
        int unsigned phase;
        int unsigned phase_end;
        int          r;
        stop_at = words_sent + RANDOM_WORDS;
        phase   = 0;
        while (words_sent < stop_at)
        begin
            case (phase)
                0: apply_config(1'b0, 1'b0, 1'b0);
                1: apply_config(1'b1, 1'b1, 1'b1);
                default: apply_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                                      1'($urandom_range(1)));
            endcase
            gaps_enabled = (phase != 2) && (phase != 7);
            phase_end = words_sent + $urandom_range(40, 110);
            while (words_sent < phase_end && words_sent < stop_at)
            begin
                r = $urandom_range(19);
                if (r == 0)
                    send_word(pick_word(last_raw), 1'($urandom_range(1)), 1'b1);
                else if (r < 3)
                    send_block($urandom_range(1, 16), 1'b1);
                else if (r == 3)
                    send_block($urandom_range(20, 40), 1'b0);
                else
                    send_block($urandom_range(1, 12), 1'b0);
                if ($urandom_range(29) == 0)
                    wait_drained();
            end
            phase++;
        end
        gaps_enabled = 1'b1;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        wr_en         <= 1'b0;
        wr_index      <= REG_STEREO_RAW_MODE;
        wr_data       <= '0;
        word_if.valid <= 1'b0;
        word_if.data  <= '0;
        clear_block_stats();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_slot_selection();
        test_conversion_modes();
        test_block_full();
        test_random_blocks();

        wait_drained();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("i2s_slot_sample_statistics_unit: match");
        else
            $display("i2s_slot_sample_statistics_unit: mismatch");
        $finish;
    end

endmodule
